[hdl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, command codes, axis limits and clamp helpers for the
// six-axis servo slew stepper.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int NUM_AXES = 6;
    localparam int MAX_AXES = 8;

    localparam logic [7:0] ELAPSED_MAX = 8'd255;
    localparam logic [7:0] DELAY_MIN   = 8'd10;
    localparam logic [7:0] DELAY_MAX   = 8'd30;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_MOVE   = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4
    } cmd_e;

    localparam logic [7:0] LIM_LO   [MAX_AXES] = '{8'd0, 8'd15, 8'd0, 8'd0,
                                                   8'd0, 8'd10, 8'd0, 8'd0};
    localparam logic [7:0] LIM_HI   [MAX_AXES] = '{8'd180, 8'd165, 8'd180, 8'd180,
                                                   8'd180, 8'd73, 8'd180, 8'd180};
    localparam logic [7:0] HOME_POS [MAX_AXES] = '{8'd0, 8'd40, 8'd180, 8'd0,
                                                   8'd170, 8'd73, 8'd0, 8'd0};

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] step_delay;
        logic [7:0] target_base;
        logic [7:0] target_shoulder;
        logic [7:0] target_elbow;
        logic [7:0] target_wrist_rotation;
        logic [7:0] target_wrist_tilt;
        logic [7:0] target_gripper;
    } item_t;

    typedef struct packed {
        logic [7:0] angle_base;
        logic [7:0] angle_shoulder;
        logic [7:0] angle_elbow;
        logic [7:0] angle_wrist_rotation;
        logic [7:0] angle_wrist_tilt;
        logic [7:0] angle_gripper;
        logic [5:0] write_mask;
        logic       moving;
        logic       paused_flag;
    } result_t;

    // Fixed limits and home position of one axis.
    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] home;
    } lane_lim_t;

    // Per-word commands broadcast from the control unit to every lane.
    typedef struct packed {
        logic step;
        logic load;
        logic snap;
    } lane_ctl_t;

    // What one lane reports back for the current word.
    typedef struct packed {
        logic [7:0] shown;
        logic       wrote;
        logic       on_next;
    } lane_stat_t;

    // Status of the control unit after the current word.
    typedef struct packed {
        logic moving;
        logic paused;
    } ctrl_stat_t;

    function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic [7:0] r;
        begin
            r = v;
            if (v < lo)
            begin
                r = lo;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    function automatic logic [4:0] clamp_delay(input logic [7:0] v);
        logic [7:0] r;
        begin
            r = clamp8(v, DELAY_MIN, DELAY_MAX);
            return r[4:0];
        end
    endfunction

endpackage

[hdl/sss_lane.sv]
// ----------------------------------------------------------------------------
// sss_lane
// One servo axis: holds its position and target, loads a clamped target, steps
// one degree toward the target or snaps to it, and reports the angle it wrote.
// ----------------------------------------------------------------------------
module sss_lane
    import sss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_lim_t  lim,
    input  lane_ctl_t  ctl,
    input  logic [7:0] target_in,
    output lane_stat_t stat
);

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [7:0] tgt_reg;
    logic [7:0] tgt_next;
    logic [7:0] pos_step;
    logic       wrote;

    assign wrote    = ctl.step && (pos_reg != tgt_reg);
    assign pos_step = (tgt_reg > pos_reg) ? pos_reg + 8'd1 : pos_reg - 8'd1;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctl.snap)
        begin
            pos_next = tgt_reg;
        end
        else if (wrote)
        begin
            pos_next = pos_step;
        end
        tgt_next = ctl.load ? clamp8(target_in, lim.lo, lim.hi) : tgt_reg;
    end

    // An axis that steps shows the angle it was written at, i.e. before the step.
    assign stat.shown   = wrote ? pos_reg : pos_next;
    assign stat.wrote   = wrote;
    assign stat.on_next = (pos_next == tgt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= lim.home;
            tgt_reg <= lim.home;
        end
        else
        begin
            pos_reg <= pos_next;
            tgt_reg <= tgt_next;
        end
    end

endmodule

[hdl/sss_ctrl.sv]
// ----------------------------------------------------------------------------
// sss_ctrl
// Command decode and merge stage: keeps the elapsed-time count, step
// interval, active and paused bits, decides when the lanes step and folds
// the lane reports into the idle decision.
// ----------------------------------------------------------------------------
module sss_ctrl
    import sss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          cmd,
    input  logic [7:0]          step_delay,
    input  logic [NUM_AXES-1:0] on_next,
    output lane_ctl_t           ctl,
    output ctrl_stat_t          stat
);

    logic [7:0] elapsed_reg;
    logic [7:0] elapsed_next;
    logic [4:0] interval_reg;
    logic [4:0] interval_next;
    logic       active_reg;
    logic       active_next;
    logic       paused_reg;
    logic       paused_next;
    logic [7:0] elapsed_inc;
    logic       running;
    logic       step;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 8'd1;
    assign running     = active_reg && !paused_reg;
    assign step        = accept && (cmd_e'(cmd) == CMD_TICK) && running
                         && (elapsed_inc > {3'b000, interval_reg});

    // Lane controls come straight from the decoded word so that the lane
    // reports never feed back into them.
    assign ctl.step = step;
    assign ctl.load = accept && (cmd_e'(cmd) == CMD_MOVE);
    assign ctl.snap = accept && (cmd_e'(cmd) == CMD_STOP);

    always_comb
    begin
        elapsed_next  = elapsed_reg;
        interval_next = interval_reg;
        active_next   = active_reg;
        paused_next   = paused_reg;
        if (accept)
        begin
            case (cmd_e'(cmd))
                CMD_TICK:
                begin
                    elapsed_next = step ? 8'd0 : elapsed_inc;
                    if (running && (&on_next))
                    begin
                        active_next = 1'b0;
                        paused_next = 1'b0;
                    end
                end
                CMD_MOVE:
                begin
                    interval_next = clamp_delay(step_delay);
                    elapsed_next  = 8'd0;
                    active_next   = 1'b1;
                end
                CMD_PAUSE:
                begin
                    paused_next = 1'b1;
                end
                CMD_RESUME:
                begin
                    paused_next = 1'b0;
                end
                CMD_STOP:
                begin
                    active_next = 1'b0;
                    paused_next = 1'b0;
                end
                default:
                begin
                    // Unused codes leave the state alone.
                end
            endcase
        end
    end

    assign stat.moving = active_next;
    assign stat.paused = paused_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= 8'd0;
            interval_reg <= DELAY_MIN[4:0];
            active_reg   <= 1'b0;
            paused_reg   <= 1'b0;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            interval_reg <= interval_next;
            active_reg   <= active_next;
            paused_reg   <= paused_next;
        end
    end

endmodule

[hdl/six_axis_servo_slew_stepper.sv]
// ----------------------------------------------------------------------------
// six_axis_servo_slew_stepper
// Steps six servo axes one degree at a time toward clamped targets, paced
// by millisecond tick words, with move, pause, resume and stop commands.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   item_t
//   result    out        result_valid / result_stall  result_t
//
// One word is accepted per clock while item_stall is low, and its result
// word is registered and shown on the next cycle. The six axis lanes and the
// control unit settle the whole word combinationally.
// After reset all axes sit at their home angles and the block is idle.
// item_stall is raised only while a result word is held and result_stall is
// high.
// ----------------------------------------------------------------------------
module six_axis_servo_slew_stepper
    import sss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic                accept;
    lane_ctl_t           ctl;
    ctrl_stat_t          cstat;
    lane_stat_t          lstat  [NUM_AXES];
    logic [7:0]          tgt_in [NUM_AXES];
    logic [NUM_AXES-1:0] on_next;
    logic [NUM_AXES-1:0] wrote;
    result_t             result_reg;
    result_t             result_next;
    logic                result_valid_reg;

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign tgt_in[0] = item.target_base;
    assign tgt_in[1] = item.target_shoulder;
    assign tgt_in[2] = item.target_elbow;
    assign tgt_in[3] = item.target_wrist_rotation;
    assign tgt_in[4] = item.target_wrist_tilt;
    assign tgt_in[5] = item.target_gripper;

    sss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (item.cmd),
        .step_delay (item.step_delay),
        .on_next    (on_next),
        .ctl        (ctl),
        .stat       (cstat)
    );

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_lane
        lane_lim_t lim;

        assign lim.lo   = LIM_LO[i];
        assign lim.hi   = LIM_HI[i];
        assign lim.home = HOME_POS[i];

        sss_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .lim       (lim),
            .ctl       (ctl),
            .target_in (tgt_in[i]),
            .stat      (lstat[i])
        );

        assign on_next[i] = lstat[i].on_next;
        assign wrote[i]   = lstat[i].wrote;
    end

    always_comb
    begin
        result_next.angle_base           = lstat[0].shown;
        result_next.angle_shoulder       = lstat[1].shown;
        result_next.angle_elbow          = lstat[2].shown;
        result_next.angle_wrist_rotation = lstat[3].shown;
        result_next.angle_wrist_tilt     = lstat[4].shown;
        result_next.angle_gripper        = lstat[5].shown;
        result_next.write_mask           = wrote;
        result_next.moving               = cstat.moving;
        result_next.paused_flag          = cstat.paused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hdl/sss_check.sv]
// ----------------------------------------------------------------------------
// sss_check
// Port-level checks for the servo slew stepper, bound to the top level.
// ----------------------------------------------------------------------------
module sss_check
    import sss_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A held result word stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // Stop ends any move at once and writes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd_e'(item.cmd) == CMD_STOP)
        |=> result_valid && (result.write_mask == 6'd0) && !result.moving
            && !result.paused_flag)
        else $error("stop did not idle the block");

    // Pause is reported right away and never comes with a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd_e'(item.cmd) == CMD_PAUSE)
        |=> result_valid && result.paused_flag && (result.write_mask == 6'd0))
        else $error("pause not reported");

    // No axis steps while stepping is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.paused_flag |-> (result.write_mask == 6'd0))
        else $error("axis stepped while paused");

endmodule

bind six_axis_servo_slew_stepper sss_check u_sss_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
